[sv/mfps_pkg.sv]
// ----------------------------------------------------------------------------
// mfps_pkg
// Shared widths, limits and arithmetic helpers for the falling path sum block.
// ----------------------------------------------------------------------------
package mfps_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int CFG_W       = 11;
  localparam int VAL_W       = 32;
  localparam int SUM_W       = 48;
  localparam int OUT_W       = 48;

  typedef logic        [COL_W-1:0] col_t;
  typedef logic        [CFG_W-1:0] cfg_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam cfg_t COLUMNS_RESET = CFG_W'(MAX_COLUMNS);
  localparam sum_t SUM_MAX       = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN       = {1'b1, {(SUM_W-1){1'b0}}};

  // Clamp the programmed column count into 1..MAX_COLUMNS.
  function automatic cfg_t eff_columns(cfg_t cols);
    cfg_t r;
    if (cols == '0) begin
      r = CFG_W'(1);
    end else if (cols > CFG_W'(MAX_COLUMNS)) begin
      r = CFG_W'(MAX_COLUMNS);
    end else begin
      r = cols;
    end
    return r;
  endfunction

  // Add an element to a path sum, clipping at the signed sum range.
  function automatic sum_t sat_add(sum_t a, val_t v);
    logic signed [SUM_W:0] s;
    sum_t                  r;
    s = {a[SUM_W-1], a} + (SUM_W+1)'(v);
    if (s[SUM_W] != s[SUM_W-1]) begin
      r = s[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      r = s[SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/mfps_ram.sv]
// ----------------------------------------------------------------------------
// mfps_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mfps_ram #(
  parameter int Depth = 1024,
  parameter int Width = 48,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read-during-write to the same address returns the old contents.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/max_falling_path_sum.sv]
// ----------------------------------------------------------------------------
// max_falling_path_sum
// Streaming maximum falling path sum over a row-major matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Program the column count on cfg_we/cfg_wdata while the block is idle
//   (reset value 1024; 0 acts as 1, larger than 1024 acts as 1024).
//   Send matrix elements on the input channel (in_valid/in_ready, value,
//   last) in row-major order. A beat with last set closes the matrix; the
//   block then returns one beat on the output channel (out_valid/out_ready,
//   best_sum) holding the best path sum of the row in progress.
//   Throughput: one element per cycle while in_ready is high. Each
//   element does one read and one write of the row-sum RAM; the
//   upper-right neighbor is read when the element is accepted and the new
//   sum is written in the next cycle. best_sum is registered from stage 1.
//   Two result slots; in_ready drops only when both are taken or reserved
//   and none leaves this cycle, so a stalled receiver holds at most two.
//   Reset (synchronous, rst high) empties the pipeline and result slots and
//   starts a new matrix; no clearing pass is needed, the RAM read data is
//   only used for entries written earlier in the same matrix.
// ----------------------------------------------------------------------------
module max_falling_path_sum (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mfps_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mfps_pkg::VAL_W-1:0]   value,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mfps_pkg::OUT_W-1:0]   best_sum
);

  // Configuration and column tracking
  mfps_pkg::cfg_t columns;
  mfps_pkg::cfg_t cols_eff;
  mfps_pkg::col_t col_idx;
  logic           first_row;
  logic           acc;
  logic           has_right;
  logic           row_end;
  mfps_pkg::col_t rd_addr;

  // Stage 1
  logic           s1_valid;
  logic           s1_last;
  logic           s1_first;
  logic           s1_col0;
  logic           s1_left_ok;
  logic           s1_right_ok;
  mfps_pkg::col_t s1_col;
  mfps_pkg::val_t s1_value;

  mfps_pkg::sum_t sum0;
  mfps_pkg::sum_t next_old;
  mfps_pkg::sum_t left_old;
  mfps_pkg::sum_t row_max;
  mfps_pkg::sum_t row_max_next;
  mfps_pkg::sum_t cur_old;
  mfps_pkg::sum_t right_sum;
  mfps_pkg::sum_t best;
  mfps_pkg::sum_t sum;
  mfps_pkg::sum_t rd_data;
  logic           fwd_hit;
  mfps_pkg::sum_t fwd_data;

  // Result slots
  logic           res_v;
  logic           pop;
  logic           skid_valid;
  mfps_pkg::sum_t skid;
  mfps_pkg::sum_t out_sum;
  logic [1:0]     pend;

  assign cols_eff  = mfps_pkg::eff_columns(columns);
  assign acc       = in_valid && in_ready;
  assign has_right = (mfps_pkg::CFG_W'(col_idx) + mfps_pkg::CFG_W'(1)) < cols_eff;
  assign row_end   = !has_right;
  assign rd_addr   = col_idx + mfps_pkg::COL_W'(1);

  assign res_v    = s1_valid && s1_last;
  assign pop      = out_valid && out_ready;
  assign pend     = 2'(out_valid) + 2'(skid_valid) + 2'(res_v);
  // A slot leaving this cycle makes room for the next result.
  assign in_ready = (pend < 2'd2) || pop;
  assign best_sum = mfps_pkg::OUT_W'(out_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= mfps_pkg::COLUMNS_RESET;
    end else if (cfg_we) begin
      columns <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx   <= '0;
      first_row <= 1'b1;
    end else if (acc) begin
      if (last) begin
        col_idx   <= '0;
        first_row <= 1'b1;
      end else if (row_end) begin
        col_idx   <= '0;
        first_row <= 1'b0;
      end else begin
        col_idx <= rd_addr;
      end
    end
  end

  // Advance one beat into stage 1; stage 1 never stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_last     <= last;
      s1_first    <= first_row;
      s1_col0     <= (col_idx == '0);
      s1_left_ok  <= (col_idx != '0);
      s1_right_ok <= has_right;
      s1_col      <= col_idx;
      s1_value    <= value;
    end
  end

  mfps_ram #(
    .Depth (mfps_pkg::MAX_COLUMNS),
    .Width (mfps_pkg::SUM_W)
  ) u_row_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (sum),
    .re    (acc),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Bypass a sum written in the same cycle as the read of its entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= s1_valid && acc && (s1_col == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= sum;
  end

  assign right_sum = fwd_hit ? fwd_data : rd_data;
  assign cur_old   = s1_col0 ? sum0 : next_old;

  always_comb begin
    best = cur_old;
    if (s1_left_ok && (left_old > best)) begin
      best = left_old;
    end
    if (s1_right_ok && (right_sum > best)) begin
      best = right_sum;
    end
    if (s1_first) begin
      sum = mfps_pkg::SUM_W'(s1_value);
    end else begin
      sum = mfps_pkg::sat_add(best, s1_value);
    end
    if (s1_col0 || (sum > row_max)) begin
      row_max_next = sum;
    end else begin
      row_max_next = row_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_old <= '0;
      row_max  <= mfps_pkg::SUM_MIN;
    end else if (s1_valid) begin
      left_old <= cur_old;
      row_max  <= s1_last ? mfps_pkg::SUM_MIN : row_max_next;
    end
  end

  // Column 0 keeps a register copy so a new row can start without a read.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      next_old <= right_sum;
      if (s1_col0) begin
        sum0 <= sum;
      end
    end
  end

  // Two-entry result buffer: output register plus skid slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_sum    <= skid;
        skid_valid <= res_v;
        skid       <= row_max_next;
      end else begin
        out_valid <= res_v;
        out_sum   <= row_max_next;
      end
    end else if (!out_valid) begin
      out_valid <= res_v;
      out_sum   <= row_max_next;
    end else if (res_v) begin
      skid_valid <= 1'b1;
      skid       <= row_max_next;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output register empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    $countones({out_valid, skid_valid, res_v}) <= 2)
    else $error("more results in flight than result slots");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res_v |=> out_valid)
    else $error("closing beat produced no output");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    (out_valid && skid_valid && !out_ready) |-> !in_ready)
    else $error("input accepted with both result slots full");
`endif

endmodule
